### hw/rtl/dmsp_pkg.sv
package dmsp_pkg;

	localparam int NODES = 32;
	localparam int NODE_W = 5;
	localparam int EDGE_ENTRIES = 256;
	localparam int EADDR_W = $clog2(EDGE_ENTRIES);
	localparam int ECNT_W = $clog2(EDGE_ENTRIES + 1);
	localparam int KEY_W = 20;
	localparam int WEIGHT_W = 10;
	localparam int EDGE_W = 2 * NODE_W + 2 * WEIGHT_W;
	localparam int IDX_W = $clog2(NODES + 1);

	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	localparam logic [KEY_W-1:0] HOP_MAX = KEY_W'(127 >> 1);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] KIND_FAST = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_BOTH = 2'd2;

	typedef struct packed {
		logic op;
		logic [NODE_W-1:0] from_node;
		logic [NODE_W-1:0] to_node;
		logic one_way;
		logic [WEIGHT_W-1:0] edge_length;
		logic [WEIGHT_W-1:0] edge_time;
		logic [NODE_W-1:0] source_node;
		logic [NODE_W-1:0] target_node;
	} in_t;

	typedef struct packed {
		logic [NODE_W-1:0] path_node;
		logic [1:0] path_kind;
		logic [KEY_W-1:0] total_time;
		logic [KEY_W-1:0] total_distance;
		logic last;
		logic store_full;
	} out_t;

	typedef struct packed {
		logic go;
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] tgt;
	} search_req_t;

	typedef struct packed {
		logic done;
		logic [KEY_W-1:0] tt;
		logic [KEY_W-1:0] td;
	} search_rsp_t;

	function automatic logic [KEY_W-1:0] sat_add(input logic [KEY_W-1:0] a,
		input logic [KEY_W-1:0] b);
		logic [KEY_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[KEY_W] ? KEY_MAX : s[KEY_W-1:0];
	endfunction

endpackage

### hw/rtl/dual_metric_shortest_path_top.sv
// A one-way edge is loaded as one edge entry and a two-way edge as two. A query
// runs two searches on one shared scan-and-relax unit: each settled node costs
// a scan of all NODES nodes plus a pass over every stored edge entry, and the
// routes are then traced and compared. Busy is high while a two-way load or an
// in-range query is in progress. Results then follow one per cycle on result
// with valid high for exactly one cycle each; the receiver cannot stall them
// and must take every one.
module dual_metric_shortest_path_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input dmsp_pkg::in_t request,
	output logic valid,
	output dmsp_pkg::out_t result
);

	typedef enum logic [3:0] {
		T_IDLE, T_LOAD2, T_SEARCH, T_TRACE_F, T_TRACE_S, T_CMP, T_EMIT_F, T_EMIT_S
	} state_t;

	localparam int NW = dmsp_pkg::NODE_W;
	localparam int IW = dmsp_pkg::IDX_W;
	localparam int CW = dmsp_pkg::ECNT_W;

	state_t state_q;
	logic [dmsp_pkg::EDGE_W-1:0] mem [dmsp_pkg::EDGE_ENTRIES];
	logic [dmsp_pkg::EDGE_W-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic [dmsp_pkg::EDGE_W-1:0] second_q;
	dmsp_pkg::in_t req_q;
	logic [dmsp_pkg::KEY_W-1:0] tt_q;
	logic [dmsp_pkg::KEY_W-1:0] td_q;
	logic [NW-1:0] rf_q [dmsp_pkg::NODES];
	logic [NW-1:0] rs_q [dmsp_pkg::NODES];
	logic [IW-1:0] nf_q;
	logic [IW-1:0] ns_q;
	logic [IW-1:0] n_q;
	logic [NW-1:0] c_q;
	logic same_q;
	logic go_q;
	logic valid_q;
	dmsp_pkg::out_t result_q;

	logic wr_en;
	logic [CW-1:0] wr_addr;
	logic [dmsp_pkg::EDGE_W-1:0] wr_data;
	logic [CW:0] need_sum;
	logic in_range_load;
	logic in_range_query;
	dmsp_pkg::search_req_t sreq;
	dmsp_pkg::search_rsp_t srsp;
	logic [dmsp_pkg::EADDR_W-1:0] edge_addr;
	logic [NW-1:0] pred_data;
	logic [IW-1:0] n_inc;

	assign busy = (state_q != T_IDLE);
	assign valid = valid_q;
	assign result = result_q;
	assign sreq = '{go: go_q, src: req_q.source_node, tgt: req_q.target_node};
	assign n_inc = n_q + IW'(1);

	always_comb begin
		need_sum = {1'b0, count_q} + (request.one_way ? (CW+1)'(1) : (CW+1)'(2));
		in_range_load = ({1'b0, request.from_node} < (NW+1)'(dmsp_pkg::NODES)) &&
			({1'b0, request.to_node} < (NW+1)'(dmsp_pkg::NODES));
		in_range_query = ({1'b0, request.source_node} < (NW+1)'(dmsp_pkg::NODES)) &&
			({1'b0, request.target_node} < (NW+1)'(dmsp_pkg::NODES));
		wr_en = 1'b0;
		wr_addr = count_q;
		wr_data = {request.edge_time, request.edge_length, request.to_node,
			request.from_node};
		if (state_q == T_LOAD2) begin
			wr_en = 1'b1;
			wr_data = second_q;
		end else if (state_q == T_IDLE && start && request.op == dmsp_pkg::OP_LOAD &&
			in_range_load && need_sum <= (CW+1)'(dmsp_pkg::EDGE_ENTRIES)) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[dmsp_pkg::EADDR_W-1:0]] <= wr_data;
		end
		rd_q <= mem[edge_addr];
	end

	dmsp_search u_search (
		.clk(clk),
		.arst_n(arst_n),
		.req(sreq),
		.rsp(srsp),
		.edge_count(count_q),
		.edge_addr(edge_addr),
		.edge_data(rd_q),
		.pred_sel(state_q == T_TRACE_S),
		.pred_addr(c_q),
		.pred_data(pred_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			count_q <= '0;
			valid_q <= 1'b0;
			go_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			go_q <= 1'b0;
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			unique case (state_q)
				T_IDLE: begin
					if (start) begin
						req_q <= request;
						second_q <= {request.edge_time, request.edge_length,
							request.from_node, request.to_node};
						if (request.op == dmsp_pkg::OP_LOAD) begin
							if (in_range_load) begin
								if (need_sum > (CW+1)'(dmsp_pkg::EDGE_ENTRIES)) begin
									valid_q <= 1'b1;
									result_q <= '{path_node: '0, path_kind: dmsp_pkg::KIND_FAST,
										total_time: '0, total_distance: '0, last: 1'b1,
										store_full: 1'b1};
								end else if (!request.one_way) begin
									state_q <= T_LOAD2;
								end
							end
						end else if (!in_range_query) begin
							valid_q <= 1'b1;
							result_q <= '{path_node: request.target_node,
								path_kind: dmsp_pkg::KIND_BOTH,
								total_time: dmsp_pkg::KEY_MAX,
								total_distance: dmsp_pkg::KEY_MAX, last: 1'b1,
								store_full: 1'b0};
						end else begin
							go_q <= 1'b1;
							state_q <= T_SEARCH;
						end
					end
				end
				T_LOAD2: state_q <= T_IDLE;
				T_SEARCH: begin
					if (srsp.done) begin
						tt_q <= srsp.tt;
						td_q <= srsp.td;
						if (srsp.tt == dmsp_pkg::KEY_MAX || srsp.td == dmsp_pkg::KEY_MAX) begin
							valid_q <= 1'b1;
							result_q <= '{path_node: req_q.target_node,
								path_kind: dmsp_pkg::KIND_BOTH,
								total_time: dmsp_pkg::KEY_MAX,
								total_distance: dmsp_pkg::KEY_MAX, last: 1'b1,
								store_full: 1'b0};
							state_q <= T_IDLE;
						end else begin
							c_q <= req_q.target_node;
							n_q <= '0;
							state_q <= T_TRACE_F;
						end
					end
				end
				T_TRACE_F, T_TRACE_S: begin
					if (state_q == T_TRACE_F) begin
						rf_q[n_q[NW-1:0]] <= c_q;
					end else begin
						rs_q[n_q[NW-1:0]] <= c_q;
					end
					n_q <= n_inc;
					c_q <= pred_data;
					if (c_q == req_q.source_node || n_inc == IW'(dmsp_pkg::NODES)) begin
						n_q <= '0;
						c_q <= req_q.target_node;
						if (state_q == T_TRACE_F) begin
							nf_q <= n_inc;
							state_q <= T_TRACE_S;
						end else begin
							ns_q <= n_inc;
							state_q <= T_CMP;
						end
					end
				end
				T_CMP: begin
					if (nf_q != ns_q || rf_q[n_q[NW-1:0]] != rs_q[n_q[NW-1:0]]) begin
						same_q <= 1'b0;
						n_q <= nf_q - IW'(1);
						state_q <= T_EMIT_F;
					end else if (n_inc == nf_q) begin
						same_q <= 1'b1;
						n_q <= nf_q - IW'(1);
						state_q <= T_EMIT_F;
					end else begin
						n_q <= n_inc;
					end
				end
				T_EMIT_F: begin
					valid_q <= 1'b1;
					result_q <= '{path_node: rf_q[n_q[NW-1:0]],
						path_kind: same_q ? dmsp_pkg::KIND_BOTH : dmsp_pkg::KIND_FAST,
						total_time: tt_q, total_distance: td_q,
						last: same_q && (n_q == '0), store_full: 1'b0};
					n_q <= n_q - IW'(1);
					if (n_q == '0) begin
						if (same_q) begin
							state_q <= T_IDLE;
						end else begin
							n_q <= ns_q - IW'(1);
							state_q <= T_EMIT_S;
						end
					end
				end
				T_EMIT_S: begin
					valid_q <= 1'b1;
					result_q <= '{path_node: rs_q[n_q[NW-1:0]],
						path_kind: dmsp_pkg::KIND_SHORT,
						total_time: tt_q, total_distance: td_q,
						last: (n_q == '0), store_full: 1'b0};
					n_q <= n_q - IW'(1);
					if (n_q == '0) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/dmsp_search.sv
module dmsp_search (
	input logic clk,
	input logic arst_n,
	input dmsp_pkg::search_req_t req,
	output dmsp_pkg::search_rsp_t rsp,
	input logic [dmsp_pkg::ECNT_W-1:0] edge_count,
	output logic [dmsp_pkg::EADDR_W-1:0] edge_addr,
	input logic [dmsp_pkg::EDGE_W-1:0] edge_data,
	input logic pred_sel,
	input logic [dmsp_pkg::NODE_W-1:0] pred_addr,
	output logic [dmsp_pkg::NODE_W-1:0] pred_data
);

	typedef enum logic [2:0] {S_IDLE, S_INIT, S_SCAN, S_EADDR, S_EEVAL} state_t;

	localparam int NW = dmsp_pkg::NODE_W;
	localparam int KW = dmsp_pkg::KEY_W;
	localparam int WW = dmsp_pkg::WEIGHT_W;

	state_t state_q;
	logic mode_q;
	logic [NW-1:0] src_q;
	logic [NW-1:0] tgt_q;
	logic [KW-1:0] k1_q [dmsp_pkg::NODES];
	logic [KW-1:0] k2_q [dmsp_pkg::NODES];
	logic settled_q [dmsp_pkg::NODES];
	logic [NW-1:0] pf_q [dmsp_pkg::NODES];
	logic [NW-1:0] ps_q [dmsp_pkg::NODES];
	logic [NW-1:0] idx_q;
	logic found_q;
	logic [NW-1:0] u_q;
	logic [KW-1:0] bu1_q;
	logic [KW-1:0] bu2_q;
	logic [dmsp_pkg::ECNT_W-1:0] e_q;
	logic [KW-1:0] tt_q;
	logic [KW-1:0] td_q;
	logic done_q;

	logic cand;
	logic better;
	logic found_n;
	logic [NW-1:0] u_n;
	logic [KW-1:0] bu1_n;
	logic [KW-1:0] bu2_n;
	logic [NW-1:0] ef;
	logic [NW-1:0] ev;
	logic [KW-1:0] elen;
	logic [KW-1:0] etm;
	logic [KW-1:0] n1;
	logic [KW-1:0] n2;
	logic relax;

	always_comb begin
		cand = !settled_q[idx_q] && (k1_q[idx_q] != dmsp_pkg::KEY_MAX);
		better = !found_q || (k1_q[idx_q] < bu1_q) ||
			((k1_q[idx_q] == bu1_q) && (k2_q[idx_q] < bu2_q));
		found_n = found_q;
		u_n = u_q;
		bu1_n = bu1_q;
		bu2_n = bu2_q;
		if (cand && better) begin
			found_n = 1'b1;
			u_n = idx_q;
			bu1_n = k1_q[idx_q];
			bu2_n = k2_q[idx_q];
		end
	end

	always_comb begin
		ef = edge_data[NW-1:0];
		ev = edge_data[2*NW-1:NW];
		elen = KW'(edge_data[2*NW+WW-1:2*NW]);
		etm = KW'(edge_data[2*NW+2*WW-1:2*NW+WW]);
		if (mode_q) begin
			n1 = dmsp_pkg::sat_add(bu1_q, elen);
			n2 = (bu2_q >= dmsp_pkg::HOP_MAX) ? dmsp_pkg::HOP_MAX : bu2_q + KW'(1);
		end else begin
			n1 = dmsp_pkg::sat_add(bu1_q, etm);
			n2 = dmsp_pkg::sat_add(bu2_q, elen);
		end
		relax = (ef == u_q) && !settled_q[ev] &&
			((n1 < k1_q[ev]) || ((n1 == k1_q[ev]) && (n2 < k2_q[ev])));
	end

	assign edge_addr = e_q[dmsp_pkg::EADDR_W-1:0];
	assign pred_data = pred_sel ? ps_q[pred_addr] : pf_q[pred_addr];
	assign rsp = '{done: done_q, tt: tt_q, td: td_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			mode_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.go) begin
						src_q <= req.src;
						tgt_q <= req.tgt;
						mode_q <= 1'b0;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					for (int i = 0; i < dmsp_pkg::NODES; i++) begin
						k1_q[i] <= dmsp_pkg::KEY_MAX;
						k2_q[i] <= mode_q ? '0 : dmsp_pkg::KEY_MAX;
						settled_q[i] <= 1'b0;
					end
					k1_q[src_q] <= '0;
					k2_q[src_q] <= '0;
					idx_q <= '0;
					found_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					found_q <= found_n;
					u_q <= u_n;
					bu1_q <= bu1_n;
					bu2_q <= bu2_n;
					idx_q <= idx_q + NW'(1);
					if (idx_q == NW'(dmsp_pkg::NODES - 1)) begin
						if (found_n) begin
							settled_q[u_n] <= 1'b1;
							e_q <= '0;
							state_q <= S_EADDR;
						end else if (!mode_q) begin
							tt_q <= k1_q[tgt_q];
							mode_q <= 1'b1;
							state_q <= S_INIT;
						end else begin
							td_q <= k1_q[tgt_q];
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_EADDR: begin
					if (e_q == edge_count) begin
						idx_q <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_EEVAL;
					end
				end
				S_EEVAL: begin
					if (relax) begin
						k1_q[ev] <= n1;
						k2_q[ev] <= n2;
						if (mode_q) begin
							ps_q[ev] <= u_q;
						end else begin
							pf_q[ev] <= u_q;
						end
					end
					e_q <= e_q + dmsp_pkg::ECNT_W'(1);
					state_q <= S_EADDR;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
